@@ hw/rtl/tms_pkg.sv @@
// Shared types and constants for the tempo melody sequencer.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

  // Field widths
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned NOTE_W  = 16;
  localparam int unsigned DUR_W   = 8;
  localparam int unsigned GATE_W  = 19;
  localparam int unsigned TEMPO_W = 10;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned CFG_IW  = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_START = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_TEMPO = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LEN   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LOOP  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_CHAN  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [TEMPO_W-1:0] TEMPO_RST = 10'd120;
  localparam logic [LEN_W-1:0]   LEN_RST   = 9'd1;

  // Serial divider geometry
  localparam int unsigned DIV_NW = 22;  // dividend and quotient bits
  localparam int unsigned DIV_DW = 10;  // divisor bits
  localparam int unsigned DIV_CW = 5;   // iteration counter bits

  // Whole note in ms times tempo, and the gate divisor
  localparam logic [DIV_NW-1:0] WHOLE_MS  = 22'd240000;
  localparam logic [DIV_DW-1:0] GATE_DIVS = 10'd10;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/tms_in_if.sv @@
// Input channel of the tempo melody sequencer: valid/ready plus one action item.
// Depends on tms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tms_in_if;
  logic                             valid;
  logic                             ready;
  logic [tms_pkg::ACT_W-1:0]        action;
  logic [tms_pkg::IDX_W-1:0]        entry_index;
  logic [tms_pkg::NOTE_W-1:0]       entry_note;
  logic signed [tms_pkg::DUR_W-1:0] entry_duration;

  modport source (
    output valid, action, entry_index, entry_note, entry_duration,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_note, entry_duration,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/tms_out_if.sv @@
// Output channel of the tempo melody sequencer: valid/ready plus one note item.
// Depends on tms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tms_out_if;
  logic                        valid;
  logic                        ready;
  logic [tms_pkg::NOTE_W-1:0]  tone_freq;
  logic [tms_pkg::GATE_W-1:0]  gate_ms;
  logic [tms_pkg::CHAN_W-1:0]  channel;
  logic                        playing;
  logic                        melody_done;

  modport source (
    output valid, tone_freq, gate_ms, channel, playing, melody_done,
    input  ready
  );
  modport sink (
    input  valid, tone_freq, gate_ms, channel, playing, melody_done,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/tempo_melody_sequencer.sv @@
// Channel   Dir  Handshake     Carries
// in_i      in   valid/ready   action, entry_index, entry_note, entry_duration
// out_o     out  valid/ready   tone_freq, gate_ms, channel, playing, melody_done
// cfg       in   cfg_we_i      cfg_idx_i selects the register, cfg_wdata_i the value
//
// Load, start and ticks that only count down are done as the item is taken and leave the sequencer idle.
// A tick that plays a note reads the table, then runs the shared 22-bit serial
// divider up to three times (whole note, note length, nine tenths gate); a rest
// skips the gate division and a zero code skips the divider. The item then passes
// S_FIN and S_EMIT into the output register; a stop goes through S_EMIT alone.
// Reset clears the play state; the note table has no reset and needs loading.
// A stalled output holds its item; the next input item is still taken meanwhile,
// but a second result waits in front of the output register and holds off input.
// Depends on tms_pkg, tms_in_if, tms_out_if and tms_div.
`timescale 1ns / 1ps
`default_nettype none

module tempo_melody_sequencer #(
  parameter int unsigned MAX_NOTES = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tms_in_if.sink                             in_i,
  tms_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tms_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  wire logic [tms_pkg::TEMPO_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned LW = $clog2(MAX_NOTES + 1);

  localparam int unsigned NOTE_W = tms_pkg::NOTE_W;
  localparam int unsigned DUR_W  = tms_pkg::DUR_W;
  localparam int unsigned GATE_W = tms_pkg::GATE_W;
  localparam int unsigned CHAN_W = tms_pkg::CHAN_W;
  localparam int unsigned DIV_NW = tms_pkg::DIV_NW;
  localparam int unsigned DIV_DW = tms_pkg::DIV_DW;
  localparam int unsigned QW     = 18;  // whole note and base length fit here

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIVW = 3'd2;
  localparam logic [2:0] S_DIVQ = 3'd3;
  localparam logic [2:0] S_DIVG = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  // Configuration registers
  logic [tms_pkg::TEMPO_W-1:0] tempo_q;
  logic [tms_pkg::LEN_W-1:0]   mlen_q;
  logic                        loop_en_q;
  logic [CHAN_W-1:0]           chan_q;

  // Play state
  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     pos_q;
  logic [GATE_W-1:0] wait_q;
  logic              playing_q;
  logic              loop_q;

  // Note work registers
  logic [NOTE_W-1:0] rd_note_q;
  logic [DUR_W-1:0]  rd_dur_q;
  logic [GATE_W-1:0] len_q, len_d;
  logic [GATE_W-1:0] gate_q, gate_d;

  // Pending result and output register
  logic              res_done_q;
  logic              res_play_q;
  logic [NOTE_W-1:0] res_freq_q;
  logic [GATE_W-1:0] res_gate_q;
  logic [CHAN_W-1:0] res_chan_q;
  logic              out_valid_q;
  logic [NOTE_W-1:0] out_freq_q;
  logic [GATE_W-1:0] out_gate_q;
  logic [CHAN_W-1:0] out_chan_q;
  logic              out_play_q;
  logic              out_done_q;

  logic [NOTE_W-1:0] note_mem [MAX_NOTES];
  logic [DUR_W-1:0]  dur_mem  [MAX_NOTES];

  logic              in_acc;
  logic              load_we;
  logic [AW-1:0]     load_addr;
  logic [GATE_W-1:0] wait_dec;
  logic              tick_note;

  tms_pkg::div_req_t div_req;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;

  logic [DIV_DW-1:0] tempo_eff;
  logic [DUR_W-1:0]  dur_mag;
  logic [QW-1:0]     quot_s;
  logic [GATE_W-1:0] len_calc;
  logic [DIV_NW-1:0] len_x9;
  logic [LW-1:0]     eff_len;
  logic [AW:0]       pos_inc;
  logic              wrap;
  logic              fin_done;
  logic              out_free;
  logic              gate_start_q;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign load_we   = in_acc && (in_i.action == tms_pkg::ACT_LOAD)
                     && (32'(in_i.entry_index) < MAX_NOTES);
  assign load_addr = AW'(in_i.entry_index);
  assign wait_dec  = (wait_q == '0) ? '0 : wait_q - 1'b1;
  assign tick_note = in_acc && (in_i.action == tms_pkg::ACT_TICK) && playing_q
                     && (wait_dec == '0);

  // Arithmetic around the divider
  assign tempo_eff = (tempo_q == '0) ? DIV_DW'(1) : tempo_q;
  assign dur_mag   = rd_dur_q[DUR_W-1] ? (~rd_dur_q + 1'b1) : rd_dur_q;
  assign quot_s    = div_quot[QW-1:0];
  assign len_calc  = rd_dur_q[DUR_W-1] ? (GATE_W'(quot_s) + GATE_W'(quot_s[QW-1:1]))
                                       : GATE_W'(quot_s);
  assign len_x9    = {len_q, 3'b000} + DIV_NW'(len_q);

  // Entries in use, clamped to the table, with a length of zero read as one
  always_comb begin
    if (mlen_q == '0) begin
      eff_len = LW'(1);
    end else if (32'(mlen_q) > MAX_NOTES) begin
      eff_len = LW'(MAX_NOTES);
    end else begin
      eff_len = LW'(mlen_q);
    end
  end

  assign pos_inc  = (AW + 1)'(pos_q) + 1'b1;
  assign wrap     = pos_inc >= (AW + 1)'(eff_len);
  assign fin_done = wrap && !loop_q;
  assign out_free = !out_valid_q || out_o.ready;

  // One-cycle marker: first cycle of S_DIVG, when len_q already holds the length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_start_q <= 1'b0;
    end else begin
      gate_start_q <= (state_q == S_DIVQ) && div_done && (rd_note_q != '0);
    end
  end

  // Sequencer
  always_comb begin
    state_d         = state_q;
    len_d           = len_q;
    gate_d          = gate_q;
    div_req.start    = 1'b0;
    div_req.dividend = tms_pkg::WHOLE_MS;
    div_req.divisor  = tempo_eff;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.action == tms_pkg::ACT_STOP) begin
          state_d = S_EMIT;
        end else if (tick_note) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (rd_dur_q == '0) begin
          len_d   = '0;
          gate_d  = '0;
          state_d = S_FIN;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NW'(quot_s);
          div_req.divisor  = DIV_DW'(dur_mag);
          state_d          = S_DIVQ;
        end
      end
      S_DIVQ: begin
        if (div_done) begin
          len_d = len_calc;
          if (rd_note_q == '0) begin
            gate_d  = '0;
            state_d = S_FIN;
          end else begin
            state_d = S_DIVG;
          end
        end
      end
      S_DIVG: begin
        // Issue the gate division once, on the first cycle here
        if (gate_start_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = len_x9;
          div_req.divisor  = tms_pkg::GATE_DIVS;
        end
        if (div_done) begin
          gate_d  = div_quot[GATE_W-1:0];
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  tms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q     <= tms_pkg::TEMPO_RST;
      mlen_q      <= tms_pkg::LEN_RST;
      loop_en_q   <= 1'b0;
      chan_q      <= '0;
      state_q     <= S_IDLE;
      pos_q       <= '0;
      wait_q      <= '0;
      playing_q   <= 1'b0;
      loop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tms_pkg::CFG_TEMPO: tempo_q   <= cfg_wdata_i;
          tms_pkg::CFG_LEN:   mlen_q    <= cfg_wdata_i[tms_pkg::LEN_W-1:0];
          tms_pkg::CFG_LOOP:  loop_en_q <= cfg_wdata_i[0];
          tms_pkg::CFG_CHAN:  chan_q    <= cfg_wdata_i[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        case (in_i.action)
          tms_pkg::ACT_START: begin
            pos_q     <= '0;
            wait_q    <= '0;
            playing_q <= 1'b1;
            loop_q    <= loop_en_q;
          end
          tms_pkg::ACT_STOP: begin
            playing_q <= 1'b0;
            loop_q    <= 1'b0;
          end
          tms_pkg::ACT_TICK: begin
            if (playing_q) begin
              wait_q <= wait_dec;
            end
          end
          default: ;
        endcase
      end
      if (state_q == S_FIN) begin
        // Reload the wait and advance past the note; wrap or finish at the end of the melody
        wait_q <= len_q;
        pos_q  <= wrap ? '0 : pos_inc[AW-1:0];
        if (fin_done) begin
          playing_q <= 1'b0;
        end
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Note table
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      note_mem[load_addr] <= in_i.entry_note;
      dur_mem[load_addr]  <= $unsigned(in_i.entry_duration);
    end
    rd_note_q <= note_mem[pos_q];
    rd_dur_q  <= dur_mem[pos_q];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    gate_q <= gate_d;
    if (state_q == S_IDLE && in_acc && in_i.action == tms_pkg::ACT_STOP) begin
      res_freq_q <= '0;
      res_gate_q <= '0;
      res_chan_q <= chan_q;
      res_play_q <= 1'b0;
      res_done_q <= 1'b0;
    end else if (state_q == S_FIN) begin
      res_freq_q <= rd_note_q;
      res_gate_q <= gate_q;
      res_chan_q <= chan_q;
      res_play_q <= !fin_done;
      res_done_q <= fin_done;
    end
    if (state_q == S_EMIT && out_free) begin
      out_freq_q <= res_freq_q;
      out_gate_q <= res_gate_q;
      out_chan_q <= res_chan_q;
      out_play_q <= res_play_q;
      out_done_q <= res_done_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.tone_freq   = out_freq_q;
  assign out_o.gate_ms     = out_gate_q;
  assign out_o.channel     = out_chan_q;
  assign out_o.playing     = out_play_q;
  assign out_o.melody_done = out_done_q;

  // Stop always leads straight to a silent result with play cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.action == tms_pkg::ACT_STOP) |=> (state_q == S_EMIT && !playing_q))
    else $error("stop did not lead to a silent result");

  // The divider only finishes while a note is being worked out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVW || state_q == S_DIVQ || state_q == S_DIVG))
    else $error("divider finished outside a note computation");

  // After a note the wait restarts at its length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (wait_q == $past(len_q)))
    else $error("wait not reloaded with the note length");

  // A final note never reports the melody as still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> !out_play_q)
    else $error("final note flagged as playing");

endmodule

`default_nettype wire

@@ hw/rtl/tms_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tms_pkg (div_req_t and divider widths).
`timescale 1ns / 1ps
`default_nettype none

module tms_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tms_pkg::div_req_t            req_i,
  output logic                              done_o,
  output logic [tms_pkg::DIV_NW-1:0]        quot_o
);

  localparam int unsigned NW = tms_pkg::DIV_NW;
  localparam int unsigned DW = tms_pkg::DIV_DW;
  localparam int unsigned CW = tms_pkg::DIV_CW;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;   // dividend shifts out the top, quotient in the bottom
  logic [DW-1:0] dvs_q, dvs_d;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire
